// File: src/u8dcc_pkg.sv
// Shared types and constants for the UTF-8 decoder and column counter.
`timescale 1ns / 1ps

package u8dcc_pkg;

    localparam int CNT_WIDTH_DEFAULT = 16;
    localparam int APB_ADDR_WIDTH    = 3;
    localparam int APB_DATA_WIDTH    = 32;
    localparam int TAB_SPAN_BITS     = 5;
    localparam int FIELD_CNT_BITS    = 16;

    localparam logic [TAB_SPAN_BITS-1:0] TAB_SPAN_RESET = 5'd8;
    localparam logic [20:0]              TAB_CODE       = 21'd9;

    localparam logic [0:0] REG_TAB_SPAN = 1'b0;

    localparam logic [7:0] MASK_ASCII = 8'h80;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] TAG_LEAD2  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] TAG_LEAD3  = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] TAG_LEAD4  = 8'hF0;
    localparam logic [7:0] PAY_LEAD2  = 8'h1F;
    localparam logic [7:0] PAY_CONT   = 8'h3F;
    localparam logic [7:0] PAY_LEAD3  = 8'h0F;
    localparam logic [7:0] PAY_LEAD4  = 8'h07;

    typedef enum logic [1:0] {
        KIND_RUNE      = 2'd0,
        KIND_INVALID   = 2'd1,
        KIND_TRUNCATED = 2'd2,
        KIND_SUMMARY   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [20:0] partial_value;
        logic [1:0]  bytes_left;
        logic [2:0]  bytes_total;
    } dec_state_t;

    typedef struct packed {
        logic [20:0]               code_point;
        logic [2:0]                rune_bytes;
        logic [FIELD_CNT_BITS-1:0] rune_index;
        logic [FIELD_CNT_BITS-1:0] column_after;
        kind_t                     result_kind;
    } result_t;

endpackage

// File: src/u8dcc_if.sv
// Stream interfaces for input bytes and decoded results.
`timescale 1ns / 1ps

interface u8dcc_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       string_end;

    modport source (output valid, output text_byte, output string_end, input ready);
    modport sink   (input valid, input text_byte, input string_end, output ready);
endinterface

interface u8dcc_result_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [2:0]  rune_bytes;
    logic [15:0] rune_index;
    logic [15:0] column_after;
    logic [1:0]  result_kind;

    modport source (output valid, output code_point, output rune_bytes, output rune_index,
                    output column_after, output result_kind, input ready);
    modport sink   (input valid, input code_point, input rune_bytes, input rune_index,
                    input column_after, input result_kind, output ready);
endinterface

// File: src/u8dcc_step.sv
// Next-state and result logic for one byte or terminator.
`timescale 1ns / 1ps

module u8dcc_step #(
    parameter int COUNT_WIDTH = u8dcc_pkg::CNT_WIDTH_DEFAULT
) (
    input  u8dcc_pkg::dec_state_t               dec,
    input  logic [COUNT_WIDTH-1:0]              char_cnt,
    input  logic [COUNT_WIDTH-1:0]              col_cnt,
    input  logic [7:0]                          text_byte,
    input  logic                                string_end,
    input  logic [u8dcc_pkg::TAB_SPAN_BITS-1:0] tab_span,
    output u8dcc_pkg::dec_state_t               dec_next,
    output logic [COUNT_WIDTH-1:0]              char_cnt_next,
    output logic [COUNT_WIDTH-1:0]              col_cnt_next,
    output logic                                emit,
    output u8dcc_pkg::result_t                  res
);
    import u8dcc_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic                   fin;
    logic [20:0]            fin_value;
    logic [2:0]             fin_bytes;
    kind_t                  fin_kind;
    logic [20:0]            cont_value;
    logic [1:0]             left_dec;
    logic [TAB_SPAN_BITS-1:0] adv;
    logic [COUNT_WIDTH:0]   col_sum;
    logic [COUNT_WIDTH:0]   char_sum;
    logic [COUNT_WIDTH-1:0] col_sat;
    logic [COUNT_WIDTH-1:0] char_sat;

    assign cont_value = {dec.partial_value[14:0], text_byte[5:0] & PAY_CONT[5:0]};
    assign left_dec   = dec.bytes_left - 2'd1;

    assign adv = (fin_kind == KIND_RUNE && fin_value == TAB_CODE)
                 ? tab_span : TAB_SPAN_BITS'(1);
    assign col_sum  = {1'b0, col_cnt} + (COUNT_WIDTH+1)'(adv);
    assign char_sum = {1'b0, char_cnt} + (COUNT_WIDTH+1)'(1);
    assign col_sat  = col_sum[COUNT_WIDTH] ? CNT_MAX : col_sum[COUNT_WIDTH-1:0];
    assign char_sat = char_sum[COUNT_WIDTH] ? CNT_MAX : char_sum[COUNT_WIDTH-1:0];

    always_comb
    begin
        dec_next      = dec;
        char_cnt_next = char_cnt;
        col_cnt_next  = col_cnt;
        emit          = 1'b0;
        fin           = 1'b0;
        fin_value     = '0;
        fin_bytes     = 3'd1;
        fin_kind      = KIND_RUNE;
        res.code_point   = '0;
        res.rune_bytes   = '0;
        res.rune_index   = FIELD_CNT_BITS'(char_cnt);
        res.column_after = FIELD_CNT_BITS'(col_cnt);
        res.result_kind  = KIND_SUMMARY;

        if (string_end)
        begin
            emit = 1'b1;
            if (dec.bytes_left != 2'd0)
            begin
                res.result_kind = KIND_TRUNCATED;
                res.rune_bytes  = dec.bytes_total - {1'b0, dec.bytes_left};
            end
            dec_next      = '0;
            char_cnt_next = '0;
            col_cnt_next  = '0;
        end
        else if (dec.bytes_left != 2'd0)
        begin
            if (left_dec == 2'd0)
            begin
                fin       = 1'b1;
                fin_value = cont_value;
                fin_bytes = dec.bytes_total;
                dec_next  = '0;
            end
            else
            begin
                dec_next.partial_value = cont_value;
                dec_next.bytes_left    = left_dec;
            end
        end
        else if ((text_byte & MASK_ASCII) == 8'h00)
        begin
            fin       = 1'b1;
            fin_value = 21'(text_byte);
        end
        else if ((text_byte & MASK_LEAD2) == TAG_LEAD2)
        begin
            dec_next.partial_value = 21'(text_byte & PAY_LEAD2);
            dec_next.bytes_left    = 2'd1;
            dec_next.bytes_total   = 3'd2;
        end
        else if ((text_byte & MASK_LEAD3) == TAG_LEAD3)
        begin
            dec_next.partial_value = 21'(text_byte & PAY_LEAD3);
            dec_next.bytes_left    = 2'd2;
            dec_next.bytes_total   = 3'd3;
        end
        else if ((text_byte & MASK_LEAD4) == TAG_LEAD4)
        begin
            dec_next.partial_value = 21'(text_byte & PAY_LEAD4);
            dec_next.bytes_left    = 2'd3;
            dec_next.bytes_total   = 3'd4;
        end
        else
        begin
            fin      = 1'b1;
            fin_kind = KIND_INVALID;
        end

        if (fin)
        begin
            emit             = 1'b1;
            char_cnt_next    = char_sat;
            col_cnt_next     = col_sat;
            res.code_point   = fin_value;
            res.rune_bytes   = fin_bytes;
            res.column_after = FIELD_CNT_BITS'(col_sat);
            res.result_kind  = fin_kind;
        end
    end

endmodule

// File: src/utf8_decode_column_counter_core.sv
// Top level of the UTF-8 decoder with display-column counter.
//
//  port     | dir  | moves per transfer
//  ---------+------+---------------------------------------------------
//  text     | in   | text_byte, string_end
//  result   | out  | code_point, rune_bytes, rune_index, column_after, result_kind
//  apb      | in   | tab_span register at byte address 0
//
//  One byte per cycle sustained while no result is stalled; an input register feeds
//  the step logic and a result register holds the output.
//  Lead and continuation bytes that finish no character give no transfer.
//  Reset clears the decoder state and counters and sets tab_span to 8.
//  A stalled result blocks only items that produce a result; others pass.
`timescale 1ns / 1ps

module utf8_decode_column_counter_core #(
    parameter int COUNT_WIDTH = u8dcc_pkg::CNT_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    u8dcc_text_if.sink                           text,
    u8dcc_result_if.source                       result,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [u8dcc_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [u8dcc_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [u8dcc_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                 pready
);
    import u8dcc_pkg::*;

    logic [TAB_SPAN_BITS-1:0]  tab_span_reg;
    logic                      cfg_write;
    logic                      cfg_hit;

    logic                      s1_valid_reg;
    logic [7:0]                s1_byte_reg;
    logic                      s1_end_reg;

    dec_state_t                dec_reg;
    dec_state_t                dec_next;
    logic [COUNT_WIDTH-1:0]    char_cnt_reg;
    logic [COUNT_WIDTH-1:0]    char_cnt_next;
    logic [COUNT_WIDTH-1:0]    col_cnt_reg;
    logic [COUNT_WIDTH-1:0]    col_cnt_next;

    logic                      emit;
    result_t                   res;
    logic                      fire;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    result_t                   out_res_reg;

    // configuration
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[APB_ADDR_WIDTH-1:2] == REG_TAB_SPAN);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
    assign prdata    = cfg_hit ? APB_DATA_WIDTH'(tab_span_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_span_reg <= TAB_SPAN_RESET;
        end
        else if (cfg_write)
        begin
            tab_span_reg <= pwdata[TAB_SPAN_BITS-1:0];
        end
    end

    u8dcc_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .dec           (dec_reg),
        .char_cnt      (char_cnt_reg),
        .col_cnt       (col_cnt_reg),
        .text_byte     (s1_byte_reg),
        .string_end    (s1_end_reg),
        .tab_span      (tab_span_reg),
        .dec_next      (dec_next),
        .char_cnt_next (char_cnt_next),
        .col_cnt_next  (col_cnt_next),
        .emit          (emit),
        .res           (res)
    );

    // advance the input stage unless its result would overwrite a waiting one
    assign fire           = s1_valid_reg && (!emit || !out_valid_reg || result.ready);
    assign text.ready     = !s1_valid_reg || fire;
    assign out_valid_next = (fire && emit) ? 1'b1 : (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            dec_reg       <= '0;
            char_cnt_reg  <= '0;
            col_cnt_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= text.valid || (s1_valid_reg && !fire);
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                dec_reg      <= dec_next;
                char_cnt_reg <= char_cnt_next;
                col_cnt_reg  <= col_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            s1_byte_reg <= text.text_byte;
            s1_end_reg  <= text.string_end;
        end
        if (fire && emit)
        begin
            out_res_reg <= res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.code_point   = out_res_reg.code_point;
    assign result.rune_bytes   = out_res_reg.rune_bytes;
    assign result.rune_index   = out_res_reg.rune_index;
    assign result.column_after = out_res_reg.column_after;
    assign result.result_kind  = out_res_reg.result_kind;

    a_idle_no_total: assert property (@(posedge clk) disable iff (!rst_n)
        dec_reg.bytes_left == 2'd0 |-> dec_reg.bytes_total == 3'd0)
        else $error("bytes_total set with no open code point");

    a_open_total: assert property (@(posedge clk) disable iff (!rst_n)
        dec_reg.bytes_left != 2'd0 |-> dec_reg.bytes_total > {1'b0, dec_reg.bytes_left})
        else $error("bytes_left not below bytes_total");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_end_reg |=> char_cnt_reg == '0 && col_cnt_reg == '0 && dec_reg == '0)
        else $error("terminator did not clear state");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !s1_end_reg |=> char_cnt_reg >= $past(char_cnt_reg)
                                && col_cnt_reg >= $past(col_cnt_reg))
        else $error("counter moved backward");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit && out_valid_reg |-> result.ready)
        else $error("result register overwritten while waiting");

endmodule
